/* rtl/tonorm_pkg.sv */
package tonorm_pkg;

  // ring geometry (depth is a power of two; fill limit stays below the depth)
  localparam int RING_DEPTH = 256;
  localparam int FILL_LIMIT = 246;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int CW         = $clog2(FILL_LIMIT + 1);
  localparam int CHAR_W     = 7;

  // front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS     = 7'h08;
  localparam logic [CHAR_W-1:0] CH_NL     = 7'h0a;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0d;
  localparam logic [CHAR_W-1:0] CH_ESC    = 7'h1b;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 7'h24;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 7'h5f;
  localparam logic [CHAR_W-1:0] CH_EMPTY  = 7'h00;

  // request codes
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // classified operation
  typedef enum logic [2:0] {
    OP_PLAIN,
    OP_BS,
    OP_CR,
    OP_NL,
    OP_SPACE,
    OP_UNDER,
    OP_PULL
  } op_class_t;

  typedef struct packed {
    op_class_t         op;
    logic [CHAR_W-1:0] ch;
  } q_entry_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // physical ring index of an offset from the read head
  function automatic logic [AW-1:0] ring_index(input logic [AW-1:0] head,
                                               input logic [CW-1:0] off);
    ring_index = head + AW'(off);
  endfunction

endpackage

/* rtl/tonorm_front.sv */
module tonorm_front
  import tonorm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_req_type,
  input  logic [7:0] in_byte_in,
  input  logic       q_full,
  output logic       q_push,
  output q_entry_t   q_data
);

  logic              ended_r;
  logic              ended_nxt;
  logic              accept;
  logic [CHAR_W-1:0] ch7;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign ch7    = in_byte_in[CHAR_W-1:0];

  // bytes after the end of source are dropped here
  assign q_push    = accept && !(ended_r && (in_req_type == REQ_BYTE));
  assign ended_nxt = ended_r || (accept && (in_req_type == REQ_PULL));

  // classify the transaction
  always_comb begin
    q_data.ch = ch7;
    q_data.op = OP_PLAIN;
    if (in_req_type == REQ_PULL) begin
      q_data.op = OP_PULL;
    end else begin
      unique case (ch7)
        CH_BS:    q_data.op = OP_BS;
        CH_CR:    q_data.op = OP_CR;
        CH_NL:    q_data.op = OP_NL;
        CH_SPACE: q_data.op = OP_SPACE;
        CH_UNDER: q_data.op = OP_UNDER;
        CH_ESC:   q_data.ch = CH_DOLLAR;
        default:  q_data.op = OP_PLAIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r <= 1'b0;
    end else begin
      ended_r <= ended_nxt;
    end
  end

endmodule

/* rtl/tonorm_queue.sv */
module tonorm_queue
  import tonorm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  q_entry_t wr_data,
  output logic     q_full,
  input  logic     rd_en,
  output logic     q_empty,
  output q_entry_t rd_data
);

  q_entry_t         entry_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == QCW'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign rd_data = entry_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/tonorm_back.sv */
module tonorm_back
  import tonorm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  q_entry_t          q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_end_of_text
);

  back_state_t       state_r, state_nxt;
  q_entry_t          op_r, op_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [CW-1:0]     ls_r, ls_nxt;
  logic [RING_DEPTH-1:0] vld_r;

  logic [CHAR_W-1:0] mem [RING_DEPTH];
  logic [CHAR_W-1:0] rd_cur_r, rd_head_r;
  logic              cur_vld_r, head_vld_r;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  logic              out_vld_r, out_vld_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_eot_r, out_eot_nxt;

  logic [CHAR_W-1:0] cell_cur, cell_head;
  logic              keep;
  logic              wr_req;
  logic [CW-1:0]     wr_off;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [CW-1:0]     cur_t, fill_t, ls_t;
  logic              do_emit, do_eom, has_res, stall, commit;
  logic              out_take;

  assign empty           = !out_vld_r;
  assign out_char_out    = out_char_r;
  assign out_end_of_text = out_eot_r;
  assign out_take        = pop && out_vld_r;

  assign rd_addr   = ring_index(head_r, cur_r);
  assign cell_cur  = cur_vld_r  ? rd_cur_r  : CH_EMPTY;
  assign cell_head = head_vld_r ? rd_head_r : CH_EMPTY;
  assign wr_addr   = ring_index(head_r, wr_off);

  // typing step: cursor move, overstrike and cell write
  always_comb begin
    keep    = 1'b0;
    wr_req  = 1'b0;
    wr_off  = cur_r;
    wr_data = op_r.ch;
    cur_t   = cur_r;
    fill_t  = fill_r;
    ls_t    = ls_r;
    unique case (op_r.op)
      OP_BS: begin
        if (cur_r > ls_r) cur_t = cur_r - 1'b1;
      end
      OP_CR: begin
        cur_t = ls_r;
      end
      OP_NL: begin
        wr_req = 1'b1;
        wr_off = fill_r;
        cur_t  = fill_r + 1'b1;
        fill_t = fill_r + 1'b1;
        ls_t   = fill_r + 1'b1;
      end
      OP_PULL: begin
        wr_req = 1'b0;
      end
      OP_PLAIN, OP_SPACE, OP_UNDER: begin
        if (op_r.op == OP_SPACE) begin
          keep = (cell_cur != CH_EMPTY);
        end else if (op_r.op == OP_UNDER) begin
          keep = (cell_cur != CH_EMPTY) && (cell_cur != CH_SPACE);
        end
        wr_req = !keep;
        cur_t  = cur_r + 1'b1;
        if (cur_t > fill_r) fill_t = fill_r + 1'b1;
      end
      default: begin
        wr_req = 1'b0;
      end
    endcase
  end

  // result decision and stall on a full output register
  always_comb begin
    if (op_r.op == OP_PULL) begin
      do_emit = (fill_r != '0);
      do_eom  = (fill_r == '0);
    end else begin
      do_emit = (fill_t >= CW'(FILL_LIMIT));
      do_eom  = 1'b0;
    end
    has_res = do_emit || do_eom;
    stall   = has_res && out_vld_r && !pop;
    commit  = (state_r == BK_EXEC) && !stall;
  end

  // sequencer: fetch op and read ring, then update and emit
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    head_nxt     = head_r;
    cur_nxt      = cur_r;
    fill_nxt     = fill_r;
    ls_nxt       = ls_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    out_vld_nxt  = out_vld_r && !out_take;
    out_char_nxt = out_char_r;
    out_eot_nxt  = out_eot_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          op_nxt    = q_data;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (commit) begin
          state_nxt = BK_IDLE;
          cur_nxt   = cur_t;
          fill_nxt  = fill_t;
          ls_nxt    = ls_t;
          if (do_eom) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = CH_EMPTY;
            out_eot_nxt  = 1'b1;
          end else if (do_emit) begin
            out_vld_nxt  = 1'b1;
            out_char_nxt = (wr_req && (wr_addr == head_r)) ? wr_data : cell_head;
            out_eot_nxt  = 1'b0;
            head_nxt     = head_r + 1'b1;
            fill_nxt     = fill_t - 1'b1;
            if (cur_t != '0) cur_nxt = cur_t - 1'b1;
            if (ls_t != '0)  ls_nxt  = ls_t - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      head_r    <= '0;
      cur_r     <= '0;
      fill_r    <= '0;
      ls_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cur_r     <= cur_nxt;
      fill_r    <= fill_nxt;
      ls_r      <= ls_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_char_r <= out_char_nxt;
    out_eot_r  <= out_eot_nxt;
  end

  // cell valid bits, an invalid cell reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (commit) begin
      if (wr_req) vld_r[wr_addr] <= 1'b1;
      if (do_emit) vld_r[head_r] <= 1'b0;
    end
  end

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (commit && wr_req) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_cur_r   <= mem[rd_addr];
      rd_head_r  <= mem[head_r];
      cur_vld_r  <= vld_r[rd_addr];
      head_vld_r <= vld_r[head_r];
    end
  end

`ifndef SYNTHESIS
  a_cur_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= fill_r)
    else $error("cursor beyond buffered text");

  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    ls_r <= cur_r)
    else $error("cursor before line start");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(FILL_LIMIT))
    else $error("fill count reached limit after update");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EXEC && !stall) |=> (state_r == BK_IDLE))
    else $error("update step did not finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !pop && state_r == BK_EXEC && has_res) |=> (state_r == BK_EXEC))
    else $error("result dropped on full output register");
`endif

endmodule

/* rtl/typewriter_overstrike_normalizer.sv */
// Typewriter overstrike normalizer. Source bytes (request type 0) are cut to
// 7 bits and typed into a 256-cell look-ahead ring at a cursor: backspace and
// carriage return move the cursor back within the current line, ESC is typed
// as '$', newline jumps to the end of the text, and a space struck over a
// filled cell, or an underscore over a filled cell that is not a space,
// keeps the old character. Once 246 characters are buffered the oldest one
// comes out as a transaction. A pull (request type 1) marks the source ended
// and returns one buffered character, or an end mark (char 0, end_of_text 1)
// when the ring is empty; bytes after that are dropped. The front end takes
// one transaction per cycle into a two-entry queue while the queue is not
// full; the back end takes the next one only once the last is done, reading
// the ring in its idle state and updating in its exec state, which waits
// while the result register holds an untaken result. The line start is kept
// in a register. Reset clears the ring at once; no clearing pass.
module typewriter_overstrike_normalizer
  import tonorm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_req_type,
  input  logic [7:0]        in_byte_in,
  output logic              empty,
  input  logic              pop,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_end_of_text
);

  logic     q_full, q_empty, q_push, q_pop;
  q_entry_t q_wr_data, q_rd_data;

  // classify incoming transactions
  tonorm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_byte_in  (in_byte_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  // decoupling queue
  tonorm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_rd_data)
  );

  // ring update and result register
  tonorm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_char_out    (out_char_out),
    .out_end_of_text (out_end_of_text)
  );

endmodule
